### src/pfp_pkg.sv
`timescale 1ns / 1ps
// Package for the PWM frequency-to-period converter.
// Holds the field widths, register indexes, status codes and sequencer states.
package pfp_pkg;

    localparam int CLK_W    = 27;
    localparam int HZ_W     = 20;
    localparam int TICK_W   = 16;
    localparam int DIVD_W   = 28;
    localparam int DIVS_W   = 20;
    localparam int CFG_A_W  = 3;
    localparam int STAT_W   = 3;

    localparam logic [CFG_A_W-1:0] REG_TIMEBASE  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_MIN_HZ    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MAX_HZ    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_DIAG_EN   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_DIAG_MAX  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_DEADBAND  = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_MIN_PULSE = 3'd6;

    localparam logic [STAT_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_LOW      = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_HIGH     = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_SHORT    = 3'd4;

    localparam logic [DIVD_W-1:0] MAX_CLOCKS = 28'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_CLOCKS,
        ST_EVAL,
        ST_DIV_ACTUAL,
        ST_DONE
    } pfp_state_t;

endpackage

### src/pwm_frequency_to_period.sv
`timescale 1ns / 1ps
// Top level of the PWM frequency-to-period converter: configuration registers,
// request checks, sequencer and result register. Uses pfp_pkg and pfp_div.
// A rejected or repeated request goes from the check straight to the result. Otherwise the
// period is computed, and the actual frequency is also recomputed when the new period is
// accepted and has changed; each division runs 28 steps on the shared divider. A stalled
// result holds the next request off. Reset is synchronous, restores defaults.
module pwm_frequency_to_period
    import pfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CLK_W-1:0]   cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,  // request_hz[19:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [63:0]        m_axis_tdata,  // period_ticks, compare_ticks, achieved_hz
    output logic [4:0]         m_axis_tuser   // accepted, status[2:0], write_timing
);

    pfp_state_t state_reg, state_next;

    logic [CLK_W-1:0]  clk_hz_reg;
    logic [HZ_W-1:0]   min_hz_reg, max_hz_reg, diag_max_reg;
    logic              diag_en_reg;
    logic [TICK_W-1:0] deadband_reg, min_pulse_reg;

    logic [TICK_W-1:0] last_period_reg;
    logic [HZ_W-1:0]   last_hz_reg;
    logic [CLK_W-1:0]  last_actual_reg;

    logic [HZ_W-1:0]   hz_reg;

    logic              res_acc_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic              res_wr_reg;
    logic [TICK_W-1:0] res_period_reg;
    logic [CLK_W-1:0]  res_actual_reg;

    logic              m_valid_reg, m_valid_next;
    logic              m_acc_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic              m_wr_reg;
    logic [TICK_W-1:0] m_period_reg;
    logic [TICK_W-1:0] m_compare_reg;
    logic [CLK_W-1:0]  m_actual_reg;

    logic              div_start, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quotient;
    logic [DIVS_W-1:0] div_divisor;

    logic              req_low, req_high, req_repeat, req_reject;
    logic              clk_zero, clk_ovf, pulse_short, eval_reject, period_changed;
    logic [TICK_W-1:0] period_new, cmp_new;
    logic [TICK_W:0]   guard;
    logic              load_out;
    logic [TICK_W:0]   res_cmp_wide;

    pfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        req_low    = (hz_reg == '0) || (hz_reg < min_hz_reg);
        req_high   = (hz_reg > max_hz_reg) && (!diag_en_reg || (hz_reg > diag_max_reg));
        req_repeat = (hz_reg == last_hz_reg) && (last_period_reg != '0);
        req_reject = req_low || req_high;

        clk_zero       = div_quotient == '0;
        clk_ovf        = div_quotient > MAX_CLOCKS;
        period_new     = div_quotient[TICK_W-1:0] - 1'b1;
        cmp_new        = div_quotient[TICK_W:1];
        guard          = {1'b0, deadband_reg} + {1'b0, min_pulse_reg};
        pulse_short    = ({1'b0, cmp_new} <= guard)
                      || ({1'b0, period_new - cmp_new} <= guard);
        eval_reject    = clk_zero || clk_ovf || pulse_short;
        period_changed = period_new != last_period_reg;

        if (state_reg == ST_CHECK) begin
            div_dividend = {1'b0, clk_hz_reg} + DIVD_W'(hz_reg >> 1);
            div_divisor  = hz_reg;
        end else begin
            div_dividend = {1'b0, clk_hz_reg};
            div_divisor  = DIVS_W'(div_quotient[TICK_W:0]);
        end

        res_cmp_wide = ({1'b0, res_period_reg} + 1'b1) >> 1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (req_reject || req_repeat) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV_CLOCKS;
                end
            end
            ST_DIV_CLOCKS: begin
                if (div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!eval_reject && period_changed) begin
                    state_next = ST_DIV_ACTUAL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_ACTUAL: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CHECK: div_start = !(req_reject || req_repeat);
            ST_EVAL:  div_start = !eval_reject && period_changed;
            ST_DONE:  load_out = !m_valid_reg || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            clk_hz_reg      <= 27'd60000000;
            min_hz_reg      <= 20'd140000;
            max_hz_reg      <= 20'd170000;
            diag_en_reg     <= 1'b0;
            diag_max_reg    <= 20'd250000;
            deadband_reg    <= 16'd36;
            min_pulse_reg   <= 16'd10;
            last_period_reg <= '0;
            last_hz_reg     <= '0;
            last_actual_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TIMEBASE:  clk_hz_reg    <= cfg_wr_data;
                    REG_MIN_HZ:    min_hz_reg    <= cfg_wr_data[HZ_W-1:0];
                    REG_MAX_HZ:    max_hz_reg    <= cfg_wr_data[HZ_W-1:0];
                    REG_DIAG_EN:   diag_en_reg   <= cfg_wr_data[0];
                    REG_DIAG_MAX:  diag_max_reg  <= cfg_wr_data[HZ_W-1:0];
                    REG_DEADBAND:  deadband_reg  <= cfg_wr_data[TICK_W-1:0];
                    REG_MIN_PULSE: min_pulse_reg <= cfg_wr_data[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_EVAL && !eval_reject) begin
                last_period_reg <= period_new;
                last_hz_reg     <= hz_reg;
            end
            if (state_reg == ST_DIV_ACTUAL && div_done) begin
                last_actual_reg <= div_quotient[CLK_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            hz_reg <= s_axis_tdata[HZ_W-1:0];
        end
        case (state_reg)
            ST_CHECK: begin
                res_acc_reg    <= !req_reject;
                res_wr_reg     <= 1'b0;
                res_period_reg <= last_period_reg;
                res_actual_reg <= last_actual_reg;
                if (req_low) begin
                    res_status_reg <= STATUS_LOW;
                end else if (req_high) begin
                    res_status_reg <= STATUS_HIGH;
                end else begin
                    res_status_reg <= STATUS_OK;
                end
            end
            ST_EVAL: begin
                res_acc_reg    <= !eval_reject;
                res_wr_reg     <= 1'b0;
                res_actual_reg <= last_actual_reg;
                if (eval_reject) begin
                    res_period_reg <= last_period_reg;
                end else begin
                    res_period_reg <= period_new;
                end
                if (clk_zero) begin
                    res_status_reg <= STATUS_SHORT;
                end else if (clk_ovf) begin
                    res_status_reg <= STATUS_OVERFLOW;
                end else if (pulse_short) begin
                    res_status_reg <= STATUS_SHORT;
                end else begin
                    res_status_reg <= STATUS_OK;
                end
            end
            ST_DIV_ACTUAL: begin
                if (div_done) begin
                    res_wr_reg     <= 1'b1;
                    res_actual_reg <= div_quotient[CLK_W-1:0];
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            m_acc_reg     <= res_acc_reg;
            m_status_reg  <= res_status_reg;
            m_wr_reg      <= res_wr_reg;
            m_period_reg  <= res_period_reg;
            m_compare_reg <= res_cmp_wide[TICK_W-1:0];
            m_actual_reg  <= res_actual_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_actual_reg, m_compare_reg, m_period_reg};
    assign m_axis_tuser  = {m_wr_reg, m_status_reg, m_acc_reg};

    a_div_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_CLOCKS || state_reg == ST_DIV_ACTUAL))
        else $error("divider finished outside a division state");

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted request did not enter the check state");

    a_accepted_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[3:1] == STATUS_OK)))
        else $error("accepted flag disagrees with status");

    a_write_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[4]) |-> m_axis_tuser[0])
        else $error("timing write on a rejected request");

endmodule

### src/pfp_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on pfp_pkg for the dividend and divisor widths.
module pfp_div
    import pfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   diff;
    logic              fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
